FILE: rtl/core/lru_k_cache_table_macros.svh
// Assertion macros shared by the lru_k_cache_table RTL.
`ifndef LRU_K_CACHE_TABLE_MACROS_SVH
`define LRU_K_CACHE_TABLE_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define LKCT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a trigger is followed by a condition in the next cycle.
`define LKCT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/lkct_pkg.sv
// Shared widths, constants and register codes of the LRU-K cache table.
package lkct_pkg;

  localparam int unsigned EntriesDef = 16;
  localparam int unsigned KeyW       = 32;
  localparam int unsigned ValW       = 32;
  localparam int unsigned CapW       = 5;
  localparam int unsigned CountW     = 4;
  localparam int unsigned InDataW    = 64;
  localparam int unsigned OutDataW   = 72;

  localparam logic [CountW-1:0] CountMax     = 4'd15;
  localparam logic [CountW-1:0] CountFirst   = 4'd1;
  localparam logic [CapW-1:0]   CapReset     = 5'd16;
  localparam logic [CountW-1:0] PromoteReset = 4'd2;
  localparam logic [ValW-1:0]   ValueMiss    = 32'hFFFF_FFFF;

  typedef enum logic {
    CfgCapacity = 1'b0,
    CfgPromote  = 1'b1
  } cfg_idx_e;

endpackage

FILE: rtl/core/lkct_lookup.sv
// Parallel key match and eviction victim select over all table entries.
module lkct_lookup import lkct_pkg::*; #(
  parameter  int unsigned Entries = EntriesDef,
  localparam int unsigned AgeW    = $clog2(Entries),
  localparam int unsigned CntW    = $clog2(Entries + 1)
) (
  input  logic [Entries-1:0]           valid_i,
  input  logic [Entries-1:0]           in_cache_i,
  input  logic [Entries-1:0][KeyW-1:0] key_i,
  input  logic [Entries-1:0][AgeW-1:0] age_i,
  input  logic [KeyW-1:0]              lookup_key_i,
  input  logic [CntW-1:0]              hist_cnt_i,
  input  logic [CntW-1:0]              used_i,
  output logic [Entries-1:0]           hit_oh_o,
  output logic [Entries-1:0]           victim_oh_o
);

  logic            victim_order;
  logic [CntW-1:0] order_cnt;
  logic [AgeW-1:0] target_age;

  assign victim_order = (hist_cnt_i == '0);
  assign order_cnt    = victim_order ? (used_i - hist_cnt_i) : hist_cnt_i;
  assign target_age   = AgeW'(order_cnt - CntW'(1));

  always_comb begin
    for (int j = 0; j < Entries; j++) begin
      hit_oh_o[j]    = valid_i[j] && (key_i[j] == lookup_key_i);
      victim_oh_o[j] = valid_i[j] && (in_cache_i[j] == victim_order)
                       && (age_i[j] == target_age);
    end
  end

endmodule

FILE: rtl/core/lru_k_cache_table.sv
// Top level of the LRU-K cache table: entry state, update logic and stream ports.
//
// Fully associative key/value table with LRU-K replacement held in flip-flops. One item is
// accepted per clock cycle while the output register is free or being taken; its result is
// registered and appears on the master side in the cycle after acceptance. Lookup, victim
// choice and each entry's age update are parallel compare logic, so throughput is one item
// per cycle when the result side takes data. Valid bits clear at reset; no clearing pass.
`include "lru_k_cache_table_macros.svh"

module lru_k_cache_table import lkct_pkg::*; #(
  parameter int unsigned Entries = EntriesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // [31:0] lookup_key, [63:32] write_value
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // [0] mode
  input  logic [0:0]          s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [0] hit, [32:1] read_value, [33] evicted, [65:34] evicted_key, [71:66] zero
  output logic [OutDataW-1:0] m_axis_tdata_o,
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_idx_i,
  input  logic [CapW-1:0]     cfg_data_i
);

  localparam int unsigned AgeW = $clog2(Entries);
  localparam int unsigned CntW = $clog2(Entries + 1);
  localparam int unsigned ExtW = (CapW > CntW) ? CapW : CntW;

  logic [Entries-1:0]             valid_q, valid_d;
  logic [Entries-1:0]             in_cache_q, in_cache_d;
  logic [Entries-1:0][KeyW-1:0]   key_q, key_d;
  logic [Entries-1:0][ValW-1:0]   value_q, value_d;
  logic [Entries-1:0][CountW-1:0] count_q, count_d;
  logic [Entries-1:0][AgeW-1:0]   age_q, age_d;
  logic [CntW-1:0]                hist_q, hist_d;
  logic [CntW-1:0]                used_q, used_d;
  logic [CapW-1:0]                cap_q, cap_d;
  logic [CountW-1:0]              promote_q, promote_d;
  logic                           out_valid_q, out_valid_d;
  logic [OutDataW-1:0]            out_data_q, out_data_d;

  logic                in_fire;
  logic                is_put;
  logic [KeyW-1:0]     in_key;
  logic [ValW-1:0]     in_value;
  logic [Entries-1:0]  hit_oh, victim_oh, free_mask, slot_oh;
  logic                hit;
  logic [ValW-1:0]     hit_value, rd_value;
  logic [CountW-1:0]   hit_count, new_count;
  logic                hit_order, new_order;
  logic [AgeW-1:0]     hit_age, vic_age;
  logic                vic_order;
  logic [KeyW-1:0]     vic_key;
  logic [ExtW-1:0]     cap_ext, cap_eff;
  logic                cap_nz, full;
  logic                do_touch, do_write_val, do_insert, do_evict;
  logic                dec, inc;

  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  assign is_put   = s_axis_tuser_i[0];
  assign in_key   = s_axis_tdata_i[KeyW-1:0];
  assign in_value = s_axis_tdata_i[KeyW+ValW-1:KeyW];

  lkct_lookup #(
    .Entries(Entries)
  ) u_lookup (
    .valid_i      (valid_q),
    .in_cache_i   (in_cache_q),
    .key_i        (key_q),
    .age_i        (age_q),
    .lookup_key_i (in_key),
    .hist_cnt_i   (hist_q),
    .used_i       (used_q),
    .hit_oh_o     (hit_oh),
    .victim_oh_o  (victim_oh)
  );

  always_comb begin
    hit_value = '0;
    hit_count = '0;
    hit_order = 1'b0;
    hit_age   = '0;
    vic_key   = '0;
    vic_order = 1'b0;
    vic_age   = '0;
    for (int j = 0; j < Entries; j++) begin
      hit_value = hit_value | ({ValW{hit_oh[j]}} & value_q[j]);
      hit_count = hit_count | ({CountW{hit_oh[j]}} & count_q[j]);
      hit_order = hit_order | (hit_oh[j] & in_cache_q[j]);
      hit_age   = hit_age | ({AgeW{hit_oh[j]}} & age_q[j]);
      vic_key   = vic_key | ({KeyW{victim_oh[j]}} & key_q[j]);
      vic_order = vic_order | (victim_oh[j] & in_cache_q[j]);
      vic_age   = vic_age | ({AgeW{victim_oh[j]}} & age_q[j]);
    end
  end

  assign hit       = |hit_oh;
  assign rd_value  = hit ? hit_value : ValueMiss;
  assign new_count = (hit_count == CountMax) ? hit_count : hit_count + CountW'(1);
  assign new_order = (new_count >= promote_q);

  assign cap_ext = ExtW'(cap_q);
  assign cap_eff = (cap_ext > ExtW'(Entries)) ? ExtW'(Entries) : cap_ext;
  assign cap_nz  = (cap_eff != '0);
  assign full    = (ExtW'(used_q) >= cap_eff);

  assign do_touch     = hit && (!is_put || cap_nz);
  assign do_write_val = hit && is_put && cap_nz;
  assign do_insert    = !hit && is_put && cap_nz;
  assign do_evict     = do_insert && full && (|victim_oh);

  assign free_mask = ~valid_q | (do_evict ? victim_oh : '0);
  assign slot_oh   = free_mask & (~free_mask + Entries'(1));

  always_comb begin
    valid_d    = valid_q;
    in_cache_d = in_cache_q;
    key_d      = key_q;
    value_d    = value_q;
    count_d    = count_q;
    age_d      = age_q;
    hist_d     = hist_q;
    used_d     = used_q;
    dec        = 1'b0;
    inc        = 1'b0;
    if (in_fire && do_touch) begin
      for (int j = 0; j < Entries; j++) begin
        if (hit_oh[j]) begin
          count_d[j]    = new_count;
          in_cache_d[j] = new_order;
          age_d[j]      = '0;
          if (do_write_val) begin
            value_d[j] = in_value;
          end
        end else if (valid_q[j]) begin
          dec      = (in_cache_q[j] == hit_order) && (age_q[j] > hit_age);
          inc      = (in_cache_q[j] == new_order);
          age_d[j] = age_q[j] - AgeW'(dec) + AgeW'(inc);
        end
      end
      if (!hit_order && new_order) begin
        hist_d = hist_q - CntW'(1);
      end else if (hit_order && !new_order) begin
        hist_d = hist_q + CntW'(1);
      end
    end
    if (in_fire && do_insert) begin
      for (int j = 0; j < Entries; j++) begin
        if (slot_oh[j]) begin
          valid_d[j]    = 1'b1;
          key_d[j]      = in_key;
          value_d[j]    = in_value;
          count_d[j]    = CountFirst;
          in_cache_d[j] = 1'b0;
          age_d[j]      = '0;
        end else if (do_evict && victim_oh[j]) begin
          valid_d[j] = 1'b0;
        end else if (valid_q[j]) begin
          dec      = do_evict && (in_cache_q[j] == vic_order) && (age_q[j] > vic_age);
          inc      = !in_cache_q[j];
          age_d[j] = age_q[j] - AgeW'(dec) + AgeW'(inc);
        end
      end
      hist_d = hist_q + CntW'(1) - CntW'(do_evict && !vic_order);
      used_d = used_q + CntW'(1) - CntW'(do_evict);
    end
  end

  always_comb begin
    cap_d     = cap_q;
    promote_d = promote_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgCapacity: cap_d = cfg_data_i;
        CfgPromote:  promote_d = cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (in_fire) begin
      out_valid_d = 1'b1;
      out_data_d  = {(OutDataW - 2 - ValW - KeyW)'(0),
                     (do_evict ? vic_key : {KeyW{1'b0}}),
                     do_evict, rd_value, hit};
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      hist_q      <= '0;
      used_q      <= '0;
      cap_q       <= CapReset;
      promote_q   <= PromoteReset;
      out_valid_q <= 1'b0;
    end else begin
      valid_q     <= valid_d;
      hist_q      <= hist_d;
      used_q      <= used_d;
      cap_q       <= cap_d;
      promote_q   <= promote_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_cache_q <= in_cache_d;
    key_q      <= key_d;
    value_q    <= value_d;
    count_q    <= count_d;
    age_q      <= age_d;
    out_data_q <= out_data_d;
  end

  `LKCT_ASSERT(a_unique_hit, $onehot0(hit_oh), "key matches more than one entry")
  `LKCT_ASSERT(a_used_bound, (used_q <= CntW'(Entries)) && (hist_q <= used_q),
               "entry counters out of range")
  `LKCT_ASSERT_NEXT(a_insert_fills, in_fire && do_insert, used_q != '0,
                    "insert left the table empty")

endmodule
